### hw/rtl/sll_pkg.sv
package sll_pkg;

   // Width of the reported length field
   localparam int LEN_W = 11;

   // Flip the sign bit so unsigned order matches signed order
   localparam logic [31:0] KEY_FLIP = 32'h8000_0000;

   // One finished result handed from the sequencer to the output stage
   typedef struct packed {
      logic [LEN_W-1:0] lis_length;
      logic             overflow;
   } sll_result_type;

endpackage

### hw/rtl/streaming_lis_length_top.sv
// Streaming longest strictly increasing subsequence length.
// Input channel req_*: one signed 32-bit sample per transaction plus a
// restart flag that empties the tail store before the sample is taken.
// Result channel rsp_*: one transaction per input, giving the length so far
// (low 11 bits) and an overflow flag for an append refused at capacity.
// The block handles one sample at a time. For an empty store or a restart
// it writes the sample as the first tail. Otherwise it reads the last tail
// and appends after it if the sample is larger; if not, it runs a binary
// search, one probe of the single-port-read tail memory per cycle, and
// overwrites the first tail not less than the sample.
// The output register lets a new sample be accepted while a result waits;
// if the receiver stalls, the next result is held inside until the output
// register frees, and no further sample is accepted meanwhile.
// Reset clears the used length and the handshake state; the tail memory
// needs no clearing since only written entries are ever read.
module streaming_lis_length_top import sll_pkg::*; #(
   parameter int MAX_LEN = 1024,
   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [31:0]      req_sample_value,
   input  logic             req_restart,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [LEN_W-1:0] rsp_lis_length,
   output logic             rsp_overflow
);

   logic           res_valid;
   logic           res_ready;
   sll_result_type res;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic [31:0]    wr_data;
   logic [AW-1:0]  rd_addr;
   logic [31:0]    rd_data;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0] rsp_lis_length_ff, rsp_lis_length_in;
   logic             rsp_overflow_ff, rsp_overflow_in;

   sll_seq #(.MAX_LEN(MAX_LEN)) u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_value (req_sample_value),
      .req_restart      (req_restart),
      .res_valid        (res_valid),
      .res_ready        (res_ready),
      .res              (res),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data)
   );

   sll_ram #(.WIDTH(32), .DEPTH(MAX_LEN)) u_tails (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Output register: load when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in      = rsp_valid_ff;
      rsp_lis_length_in = rsp_lis_length_ff;
      rsp_overflow_in   = rsp_overflow_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in      = 1'b1;
         rsp_lis_length_in = res.lis_length;
         rsp_overflow_in   = res.overflow;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_lis_length_ff <= rsp_lis_length_in;
      rsp_overflow_ff   <= rsp_overflow_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_lis_length = rsp_lis_length_ff;
   assign rsp_overflow   = rsp_overflow_ff;

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      res_valid && !res_ready |=> res_valid)
      else $error("finished result lost while output full");

   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      res_valid && res_ready |=> rsp_valid)
      else $error("result not presented after load");

   a_idle_out: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> res_ready)
      else $error("empty output register refused a result");

endmodule

### hw/rtl/sll_ram.sv
module sll_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry with a registered result
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/sll_seq.sv
module sll_seq import sll_pkg::*; #(
   parameter int MAX_LEN = 1024,
   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
   localparam int LW = $clog2(MAX_LEN + 1)
) (
   input  logic           clock,
   input  logic           reset,
   // incoming transaction
   input  logic           req_valid,
   output logic           req_ready,
   input  logic [31:0]    req_sample_value,
   input  logic           req_restart,
   // finished result
   output logic           res_valid,
   input  logic           res_ready,
   output sll_result_type res,
   // tail store port
   output logic           wr_en,
   output logic [AW-1:0]  wr_addr,
   output logic [31:0]    wr_data,
   output logic [AW-1:0]  rd_addr,
   input  logic [31:0]    rd_data
);

   typedef enum logic [1:0] {
      IDLE,
      LAST,
      PROBE,
      DONE
   } state_type;

   state_type      state_ff, state_in;
   logic [31:0]    key_ff, key_in;
   logic [LW-1:0]  used_ff, used_in;
   logic [AW-1:0]  lo_ff, lo_in;
   logic [AW-1:0]  hi_ff, hi_in;
   logic [AW-1:0]  mid_ff, mid_in;
   logic           ovf_ff, ovf_in;

   logic           tail_less;
   logic [LW-1:0]  used_m1;
   logic [AW-1:0]  lo_n, hi_n;
   logic [AW:0]    mid_sum;
   logic [LW+LEN_W-1:0] used_ext;

   // Shared compare unit: stored tail against the current key
   assign tail_less = rd_data < key_ff;
   assign used_m1   = used_ff - 1'b1;

   // Open the window on the whole used store after the last tail is read, else narrow it from the probe just read
   always_comb begin
      lo_n = lo_ff;
      hi_n = hi_ff;
      if (state_ff == LAST) begin
         lo_n = '0;
         hi_n = used_m1[AW-1:0];
      end else if (tail_less) begin
         lo_n = mid_ff + 1'b1;
      end else begin
         hi_n = mid_ff;
      end
   end

   assign mid_sum = {1'b0, lo_n} + {1'b0, hi_n};

   // Sequencer next-state and store control
   always_comb begin
      state_in = state_ff;
      key_in   = key_ff;
      used_in  = used_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      ovf_in   = ovf_ff;
      wr_en    = 1'b0;
      wr_addr  = lo_n;
      wr_data  = key_ff;
      rd_addr  = mid_sum[AW:1];
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               key_in = req_sample_value ^ KEY_FLIP;
               ovf_in = 1'b0;
               if (req_restart || used_ff == '0) begin
                  // empty store or restart: the value becomes the first tail
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  wr_data  = key_in;
                  used_in  = LW'(1);
                  state_in = DONE;
               end else begin
                  rd_addr  = used_m1[AW-1:0];
                  state_in = LAST;
               end
            end
         end
         LAST: begin
            if (tail_less) begin
               // append, or refuse when the store is full
               if (used_ff == LW'(MAX_LEN)) begin
                  ovf_in = 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = used_ff[AW-1:0];
                  used_in = used_ff + 1'b1;
               end
               state_in = DONE;
            end else if (lo_n == hi_n) begin
               wr_en    = 1'b1;
               state_in = DONE;
            end else begin
               lo_in    = lo_n;
               hi_in    = hi_n;
               mid_in   = mid_sum[AW:1];
               state_in = PROBE;
            end
         end
         PROBE: begin
            if (lo_n == hi_n) begin
               // lower bound found: overwrite that tail
               wr_en    = 1'b1;
               state_in = DONE;
            end else begin
               lo_in  = lo_n;
               hi_in  = hi_n;
               mid_in = mid_sum[AW:1];
            end
         end
         DONE: begin
            if (res_ready) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // Hold state and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
      end
      key_ff <= key_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      ovf_ff <= ovf_in;
   end

   assign used_ext       = {{LEN_W{1'b0}}, used_ff};
   assign req_ready      = (state_ff == IDLE);
   assign res_valid      = (state_ff == DONE);
   assign res.lis_length = used_ext[LEN_W-1:0];
   assign res.overflow   = ovf_ff;

   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      used_ff <= LW'(MAX_LEN))
      else $error("used length beyond capacity");

   a_probe_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == PROBE |-> (lo_ff < hi_ff) && (mid_ff >= lo_ff) && (mid_ff < hi_ff))
      else $error("search window collapsed while probing");

   a_done_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == DONE |-> used_ff != '0)
      else $error("result with empty store");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted while busy");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en && state_ff != IDLE |-> LW'(wr_addr) < used_in)
      else $error("tail write beyond used length");

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

import sll_pkg::*;

// Track the patience-sorting tails and check each result against them
class lis_scoreboard;
   int unsigned        depth;
   logic signed [31:0] tail_vals[];
   int unsigned        used_len;
   sll_result_type     results_due[$];
   int unsigned        errors;
   int unsigned        samples;
   int unsigned        results;
   int unsigned        restarts;
   int unsigned        replaces;
   int unsigned        overflows;
   int unsigned        peak_len;

   function new(int unsigned capacity);
      depth      = capacity;
      tail_vals  = new[capacity];
      used_len   = 0;
      errors     = 0;
      samples    = 0;
      results    = 0;
      restarts   = 0;
      replaces   = 0;
      overflows  = 0;
      peak_len   = 0;
   endfunction

   function int pending();
      return results_due.size();
   endfunction

   // Update the tails for one accepted transaction and queue its result
   function void take_sample(logic signed [31:0] value, logic restart);
      sll_result_type res;
      int unsigned    lo;
      int unsigned    hi;
      int unsigned    mid;
      res.overflow = 1'b0;
      samples++;
      if (restart) begin
         used_len = 0;
         restarts++;
      end
      if (used_len == 0) begin
         tail_vals[0] = value;
         used_len = 1;
      end else if (value > tail_vals[used_len-1]) begin
         // append unless the store is already full
         if (used_len < depth) begin
            tail_vals[used_len] = value;
            used_len++;
         end else begin
            res.overflow = 1'b1;
            overflows++;
         end
      end else begin
         // find the first tail not less than the value
         lo = 0;
         hi = used_len - 1;
         while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (tail_vals[mid] < value)
               lo = mid + 1;
            else
               hi = mid;
         end
         tail_vals[lo] = value;
         replaces++;
      end
      res.lis_length = LEN_W'(used_len);
      if (used_len > peak_len)
         peak_len = used_len;
      results_due = {results_due, res};
   endfunction

   // Print one line per mismatch (first hundred) and count all of them
   task report(string msg);
      errors++;
      if (errors <= 100)
         $display("[%0t] ERROR: %s", $time, msg);
   endtask

   // Compare one result transaction with the oldest expectation
   task check_result(logic [LEN_W-1:0] got_len, logic got_ovf);
      sll_result_type want;
      results++;
      if (results_due.size() == 0) begin
         report($sformatf("unexpected result: length %0d overflow %b", got_len, got_ovf));
         return;
      end
      want = results_due.pop_front();
      if (got_len !== want.lis_length)
         report($sformatf("result %0d: length %0d, want %0d",
                          results, got_len, want.lis_length));
      if (got_ovf !== want.overflow)
         report($sformatf("result %0d: overflow %b, want %b",
                          results, got_ovf, want.overflow));
   endtask
endclass

module tb;

   localparam int CAPACITY = 1024;

   typedef enum int {SEG_WIDE, SEG_NARROW, SEG_RISING, SEG_EDGES} seg_kind_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic [31:0]      req_sample_value;
   logic             req_restart;
   logic             rsp_valid;
   logic             rsp_ready;
   logic [LEN_W-1:0] rsp_lis_length;
   logic             rsp_overflow;

   lis_scoreboard sb;
   bit            steady_send;

   streaming_lis_length_top #(.MAX_LEN(CAPACITY)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_value (req_sample_value),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_lis_length   (rsp_lis_length),
      .rsp_overflow     (rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Bound the run
   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // Watch both channels; note inputs before checking results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.take_sample(req_sample_value, req_restart);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_lis_length, rsp_overflow);
      end
   end

   // Stall the result channel: free stretches, short flickers, long holds
   initial begin
      int mode;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         mode = $urandom_range(0, 9);
         if (mode < 3) begin
            rsp_ready = 1'b1;
            repeat ($urandom_range(20, 200)) @(negedge clock);
         end else if (mode < 8) begin
            rsp_ready = 1'b1;
            repeat ($urandom_range(1, 4)) @(negedge clock);
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
         end else begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(10, 40)) @(negedge clock);
         end
      end
   end

   // Pick an idle gap before the next transaction
   function automatic int pick_gap();
      int r;
      if (steady_send)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one sample and hold it until accepted
   task automatic send_sample(input logic [31:0] value, input logic restart);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        = 1'b1;
      req_sample_value = value;
      req_restart      = restart;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Send segments of random samples, each opened by a restart most of the time
   task automatic run_random(input int unsigned budget);
      int unsigned  sent;
      seg_kind_type kind;
      int           seg_len;
      int           trend;
      logic [31:0]  value;
      logic         restart;
      sent = 0;
      while (sent < budget) begin
         kind = seg_kind_type'($urandom_range(0, 3));
         if (kind == SEG_RISING && $urandom_range(0, 2) == 0)
            seg_len = $urandom_range(150, 300);
         else
            seg_len = $urandom_range(5, 80);
         steady_send = ($urandom_range(0, 3) == 0);
         trend = $urandom;
         for (int i = 0; i < seg_len && sent < budget; i++) begin
            case (kind)
               SEG_WIDE: begin
                  value = $urandom;
               end
               SEG_NARROW: begin
                  value = $urandom_range(0, 16) - 8;
               end
               SEG_RISING: begin
                  // climb slowly with noise so the length grows deep
                  trend += $urandom_range(0, 5);
                  value = trend - $urandom_range(0, 10);
               end
               default: begin
                  case ($urandom_range(0, 7))
                     0:       value = 32'h8000_0000;
                     1:       value = 32'h8000_0001;
                     2:       value = 32'hFFFF_FFFF;
                     3:       value = 32'h0000_0000;
                     4:       value = 32'h0000_0001;
                     5:       value = 32'h7FFF_FFFE;
                     6:       value = 32'h7FFF_FFFF;
                     default: value = $urandom;
                  endcase
               end
            endcase
            if (i == 0)
               restart = ($urandom_range(0, 5) != 0);
            else
               restart = ($urandom_range(0, 39) == 0);
            send_sample(value, restart);
            sent++;
         end
      end
      steady_send = 1'b0;
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sample_value = 32'h0;
      req_restart      = 1'b0;
      steady_send      = 1'b0;
      sb = new(CAPACITY);
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty store, equal tails, extremes, restart
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'h7FFF_FFFF, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h0000_0005, 1'b0);
      send_sample(32'h0000_0005, 1'b0);
      send_sample(32'h0000_0006, 1'b0);
      send_sample(32'h0000_0002, 1'b0);
      send_sample(32'h7FFF_FFFF, 1'b1);
      send_sample(32'hAAAA_AAAA, 1'b0);
      send_sample(32'h5555_5555, 1'b0);
      send_sample(32'h8000_0000, 1'b1);
      send_sample(32'h8000_0001, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h7FFF_FFFE, 1'b0);
      send_sample(32'h7FFF_FFFF, 1'b0);
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'h0000_0000, 1'b1);

      run_random(790);

      run_random(40);

      // Drain, then allow for the longest search
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (30) @(posedge clock);

      $display("Ran %0d samples: %0d restarts, %0d searched replacements, %0d refused appends.",
               sb.samples, sb.restarts, sb.replaces, sb.overflows);
      $display("Checked %0d results, longest length %0d, mismatches %0d.",
               sb.results, sb.peak_len, sb.errors);
      if (sb.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
